// ===== rtl/dipc_pkg.sv =====
// shared types, codes and constants for the debounced change-of-state i/o ports
`default_nettype none

package dipc_pkg;

  localparam logic [7:0] DebounceRst = 8'd4;
  localparam logic [7:0] DebounceMax = 8'hFE;
  localparam logic [7:0] DebounceTop = 8'hFF;
  localparam logic [7:0] MaskRst     = 8'hFF;
  localparam logic [7:0] LevelRst    = 8'hFF;
  localparam logic [7:0] CountSat    = 8'hFF;
  localparam logic [7:0] LenErrByte1 = 8'h10;
  localparam logic [7:0] LenErrByte2 = 8'h82;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_RD_IN  = 2'd2,
    CMD_RD_OUT = 2'd3
  } dipc_cmd_e;

  typedef enum logic [1:0] {
    KIND_REPORT  = 2'd0,
    KIND_IN_READ = 2'd1,
    KIND_OUT_RD  = 2'd2,
    KIND_LEN_ERR = 2'd3
  } dipc_kind_e;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_COS_EN   = 3'd1,
    REG_MASK_A   = 3'd2,
    REG_MASK_B   = 3'd3,
    REG_OUT_MASK = 3'd4
  } dipc_reg_e;

  typedef enum logic [1:0] {
    PORT_NONE = 2'd0,
    PORT_A    = 2'd1,
    PORT_B    = 2'd2,
    PORT_RSVD = 2'd3
  } dipc_port_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
    logic       tx_busy;
    logic [3:0] data_length;
    logic [7:0] out_byte_a;
    logic [7:0] out_byte_b;
    logic [1:0] port_select;
  } dipc_item_t;

  typedef struct packed {
    dipc_kind_e kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } dipc_res_t;

  typedef struct packed {
    logic [7:0] debounce_polls;
    logic       cos_enable;
    logic [7:0] cos_mask_a;
    logic [7:0] cos_mask_b;
    logic [7:0] out_mask;
  } dipc_cfg_t;

  typedef struct packed {
    logic [7:0] last_a;
    logic [7:0] last_b;
    logic [7:0] count;
    logic [7:0] level_a;
    logic [7:0] level_b;
  } dipc_state_t;

endpackage

`default_nettype wire

// ===== rtl/dipc_if.sv =====
// valid/ready channel interfaces for command items and result items
`default_nettype none

interface dipc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] pins_a;
  logic [7:0] pins_b;
  logic       tx_busy;
  logic [3:0] data_length;
  logic [7:0] out_byte_a;
  logic [7:0] out_byte_b;
  logic [1:0] port_select;

  modport source (
    output valid, cmd, pins_a, pins_b, tx_busy, data_length, out_byte_a, out_byte_b,
           port_select,
    input  ready
  );
  modport sink (
    input  valid, cmd, pins_a, pins_b, tx_busy, data_length, out_byte_a, out_byte_b,
           port_select,
    output ready
  );
endinterface

interface dipc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (output valid, kind, first_byte, second_byte, input ready);
  modport sink (input valid, kind, first_byte, second_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dipc_core.sv =====
// combinational item processing: debounce compare, output latch update, reads
`default_nettype none

module dipc_core (
  input  dipc_pkg::dipc_item_t  item_i,
  input  dipc_pkg::dipc_cfg_t   cfg_i,
  input  dipc_pkg::dipc_state_t state_i,
  output dipc_pkg::dipc_state_t state_o,
  output logic                  res_valid_o,
  output dipc_pkg::dipc_res_t   res_o
);
  import dipc_pkg::*;

  logic [7:0] in_mask_b;
  logic [7:0] cur_a;
  logic [7:0] cur_b;
  logic       same;
  logic [7:0] count_inc;

  assign in_mask_b = ~cfg_i.out_mask;
  assign cur_a     = item_i.pins_a & cfg_i.cos_mask_a;
  assign cur_b     = item_i.pins_b & in_mask_b & cfg_i.cos_mask_b;
  assign same      = (cur_a == state_i.last_a) && (cur_b == state_i.last_b);
  assign count_inc = (state_i.count == CountSat) ? CountSat : state_i.count + 8'd1;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_REPORT, first_byte: 8'h00, second_byte: 8'h00};
    case (dipc_cmd_e'(item_i.cmd))
      CMD_POLL: begin
        if (cfg_i.cos_enable) begin
          if (same) begin
            state_o.count = 8'h00;
          end else begin
            state_o.count = count_inc;
            // report once the change outlasted the debounce window and tx is free
            if ((count_inc > cfg_i.debounce_polls) && !item_i.tx_busy) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_REPORT;
              res_o.first_byte  = item_i.pins_a;
              res_o.second_byte = item_i.pins_b & in_mask_b;
              state_o.last_a    = cur_a;
              state_o.last_b    = cur_b;
            end
          end
        end
      end
      CMD_WRITE: begin
        if (item_i.data_length == 4'd0) begin
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_LEN_ERR;
          res_o.first_byte  = LenErrByte1;
          res_o.second_byte = LenErrByte2;
        end else begin
          state_o.level_a = item_i.out_byte_a;
          if (item_i.data_length >= 4'd2) begin
            state_o.level_b = (state_i.level_b & in_mask_b) |
                              (item_i.out_byte_b & cfg_i.out_mask);
          end
        end
      end
      CMD_RD_IN: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_IN_READ;
        case (dipc_port_e'(item_i.port_select))
          PORT_A:  res_o.first_byte = item_i.pins_a;
          PORT_B:  res_o.first_byte = item_i.pins_b & in_mask_b;
          default: res_o.first_byte = 8'h00;
        endcase
      end
      CMD_RD_OUT: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_OUT_RD;
        case (dipc_port_e'(item_i.port_select))
          PORT_A:  res_o.first_byte = state_i.level_a;
          PORT_B:  res_o.first_byte = state_i.level_b & cfg_i.out_mask;
          default: res_o.first_byte = 8'h00;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/digital_io_ports_debounced_cos.sv =====
// top level: two 8-bit i/o ports with debounced change-of-state reporting
`default_nettype none

// Two 8-bit digital ports: port A is input only with its own output latch, port B pins are
// outputs where out_mask is 1 and inputs elsewhere. Command items poll the pins,
// write the output latches or read back masked levels; a poll reports a change of the
// watched inputs once it has been seen on more than debounce_polls polls in a row and the
// transmitter is free. The block takes one item per clock cycle while the result side
// takes transfers. Each item is registered on acceptance and its result, if any, is
// registered in the output register when the item leaves the input register; a stalled
// output register holds the input register, and both sides keep moving as long as the
// result side takes transfers. Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i
// take effect at the write edge and are meant for idle periods; a debounce value of 255
// is stored as 254 and indexes beyond the register list are ignored.
module digital_io_ports_debounced_cos (
  input  wire        clk_i,
  input  wire        rst_ni,
  dipc_in_if.sink    in_i,
  dipc_out_if.source out_o,
  input  wire        cfg_we_i,
  input  wire  [2:0] cfg_idx_i,
  input  wire  [7:0] cfg_data_i
);
  import dipc_pkg::*;

  // configuration registers
  dipc_cfg_t   cfg_q;

  // persistent port state
  dipc_state_t state_q;
  dipc_state_t state_d;

  // input register stage
  dipc_item_t  item_q;
  dipc_item_t  item_d;
  logic        item_valid_q;

  // result register stage
  dipc_res_t   res_q;
  dipc_res_t   res_d;
  logic        res_valid_d;
  logic        out_valid_q;

  logic        in_xfer;
  logic        advance;

  assign item_d = '{cmd:         in_i.cmd,
                    pins_a:      in_i.pins_a,
                    pins_b:      in_i.pins_b,
                    tx_busy:     in_i.tx_busy,
                    data_length: in_i.data_length,
                    out_byte_a:  in_i.out_byte_a,
                    out_byte_b:  in_i.out_byte_b,
                    port_select: in_i.port_select};

  // the registered item moves on whenever the result slot is free or being emptied
  assign advance    = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  dipc_core u_core (
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (res_valid_d),
    .res_o       (res_d)
  );

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{debounce_polls: DebounceRst,
                 cos_enable:     1'b0,
                 cos_mask_a:     MaskRst,
                 cos_mask_b:     MaskRst,
                 out_mask:       MaskRst};
    end else if (cfg_we_i) begin
      case (dipc_reg_e'(cfg_idx_i))
        REG_DEBOUNCE: cfg_q.debounce_polls <= (cfg_data_i == DebounceTop) ? DebounceMax
                                                                           : cfg_data_i;
        REG_COS_EN:   cfg_q.cos_enable     <= cfg_data_i[0];
        REG_MASK_A:   cfg_q.cos_mask_a     <= cfg_data_i;
        REG_MASK_B:   cfg_q.cos_mask_b     <= cfg_data_i;
        REG_OUT_MASK: cfg_q.out_mask       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

  // debounce state and output latches commit when the item leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{last_a: 8'h00, last_b: 8'h00, count: 8'h00,
                   level_a: LevelRst, level_b: LevelRst};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (advance && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.first_byte  = res_q.first_byte;
  assign out_o.second_byte = res_q.second_byte;

endmodule

`default_nettype wire

// ===== rtl/dipc_checker.sv =====
// port-level assertions for the debounced change-of-state i/o ports, with bind
`default_nettype none

module dipc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [1:0] kind_i,
  input wire [7:0] first_byte_i,
  input wire [7:0] second_byte_i
);
  import dipc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(kind_i) && $stable(first_byte_i) &&
                                    $stable(second_byte_i))
    else $error("result payload changed while stalled");

  // a fresh result must be preceded by a matching input transfer
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching input transfer");

  // length errors carry the fixed error code bytes
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_LEN_ERR) |->
      (first_byte_i == LenErrByte1) && (second_byte_i == LenErrByte2))
    else $error("length error result has wrong code bytes");

endmodule

bind digital_io_ports_debounced_cos dipc_checker u_dipc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .first_byte_i  (out_o.first_byte),
  .second_byte_i (out_o.second_byte)
);

`default_nettype wire

// ===== test/tb_digital_io_ports_debounced_cos.sv =====
// testbench for the debounced change-of-state i/o ports: directed table, random phases, checker
`timescale 1ns / 100ps

module tb_digital_io_ports_debounced_cos;
  import dipc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;    // margin past the item and result registers
  localparam int unsigned HoldCycles  = 300;  // long result-side hold-off
  localparam int unsigned MaxReports  = 10;
  localparam logic [2:0]  RegNone     = 3'd7; // index past the register list

  typedef enum logic {
    STEP_ITEM,
    STEP_REG
  } step_e;

  // one row of the directed table: either an item or a register write
  typedef struct {
    step_e      kind;
    dipc_item_t item;
    bit         fixed;  // expected result typed in below instead of predicted
    dipc_res_t  res;
    logic [2:0] idx;
    logic [7:0] data;
  } step_t;

  // one random phase: register settings, idling and item mix
  typedef struct {
    dipc_cfg_t   cfg;
    int unsigned tx_idle;
    int unsigned rx_stall;
    int unsigned n_items;
    bit          hold;
    bit          poll_heavy;
  } phase_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  dipc_in_if  cmd_if ();
  dipc_out_if res_if ();

  digital_io_ports_debounced_cos i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor copy of registers and port state
  dipc_cfg_t   port_cfg;
  dipc_state_t port_st;

  // results still owed by the block, oldest first
  dipc_res_t   expected_q[$];

  step_t       directed_steps[$];
  phase_t      phases[$];

  // typed-in expectation travels with the item, so it is sampled at the same edge
  logic        fixed_on;
  dipc_res_t   fixed_res;

  logic        hold_off;
  bit          hold_go      = 1'b0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;

  // slowly changing pin levels seen by the random polls
  logic [7:0]  env_a = 8'h00;
  logic [7:0]  env_b = 8'h00;

  dipc_item_t  seen_item;
  dipc_res_t   seen_res;
  dipc_res_t   want_res;
  bit          seen_hit;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_ports();
    port_cfg.debounce_polls = DebounceRst;
    port_cfg.cos_enable     = 1'b0;
    port_cfg.cos_mask_a     = MaskRst;
    port_cfg.cos_mask_b     = MaskRst;
    port_cfg.out_mask       = MaskRst;
    port_st.last_a          = 8'h00;
    port_st.last_b          = 8'h00;
    port_st.count           = 8'h00;
    port_st.level_a         = LevelRst;
    port_st.level_b         = LevelRst;
  endfunction

  function automatic void set_port_reg(input logic [2:0] idx, input logic [7:0] data);
    case (idx)
      REG_DEBOUNCE: port_cfg.debounce_polls = (data == DebounceTop) ? DebounceMax : data;
      REG_COS_EN:   port_cfg.cos_enable     = data[0];
      REG_MASK_A:   port_cfg.cos_mask_a     = data;
      REG_MASK_B:   port_cfg.cos_mask_b     = data;
      REG_OUT_MASK: port_cfg.out_mask       = data;
      default: ;
    endcase
  endfunction

  // updates the port state for one item, returns 1 when the item yields a result
  function automatic bit predict_ports(input dipc_item_t it, output dipc_res_t res);
    logic [7:0] in_mask_b;
    logic [7:0] cur_a;
    logic [7:0] cur_b;
    logic [7:0] rd;
    bit         hit;
    in_mask_b = ~port_cfg.out_mask;
    res       = '0;
    hit       = 1'b0;
    rd        = 8'h00;
    case (dipc_cmd_e'(it.cmd))
      CMD_POLL: begin
        if (port_cfg.cos_enable) begin
          cur_a = it.pins_a & port_cfg.cos_mask_a;
          cur_b = it.pins_b & in_mask_b & port_cfg.cos_mask_b;
          if (cur_a == port_st.last_a && cur_b == port_st.last_b) begin
            port_st.count = 8'h00;
          end else begin
            // count saturates instead of wrapping
            if (port_st.count != CountSat) port_st.count = port_st.count + 8'd1;
            if (port_st.count > port_cfg.debounce_polls && !it.tx_busy) begin
              res.kind        = KIND_REPORT;
              res.first_byte  = it.pins_a;
              res.second_byte = it.pins_b & in_mask_b;
              port_st.last_a  = cur_a;
              port_st.last_b  = cur_b;
              hit             = 1'b1;
            end
          end
        end
      end
      CMD_WRITE: begin
        if (it.data_length == 4'd0) begin
          res.kind        = KIND_LEN_ERR;
          res.first_byte  = LenErrByte1;
          res.second_byte = LenErrByte2;
          hit             = 1'b1;
        end else begin
          port_st.level_a = it.out_byte_a;
          // input bits of port b keep their pull-up level
          if (it.data_length >= 4'd2)
            port_st.level_b = (port_st.level_b & in_mask_b) | (it.out_byte_b & port_cfg.out_mask);
        end
      end
      CMD_RD_IN: begin
        if (it.port_select == PORT_A) rd = it.pins_a;
        else if (it.port_select == PORT_B) rd = it.pins_b & in_mask_b;
        res.kind       = KIND_IN_READ;
        res.first_byte = rd;
        hit            = 1'b1;
      end
      default: begin
        if (it.port_select == PORT_A) rd = port_st.level_a;
        else if (it.port_select == PORT_B) rd = port_st.level_b & port_cfg.out_mask;
        res.kind       = KIND_OUT_RD;
        res.first_byte = rd;
        hit            = 1'b1;
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // table and item builders
  // ---------------------------------------------------------------------------

  function automatic step_t item_step(input dipc_cmd_e cmd, input logic [7:0] pins_a,
                                      input logic [7:0] pins_b, input logic busy,
                                      input logic [3:0] len, input logic [7:0] byte_a,
                                      input logic [7:0] byte_b, input dipc_port_e port);
    step_t s;
    s.kind               = STEP_ITEM;
    s.item.cmd           = cmd;
    s.item.pins_a        = pins_a;
    s.item.pins_b        = pins_b;
    s.item.tx_busy       = busy;
    s.item.data_length   = len;
    s.item.out_byte_a    = byte_a;
    s.item.out_byte_b    = byte_b;
    s.item.port_select   = port;
    s.fixed              = 1'b0;
    s.res                = '0;
    s.idx                = '0;
    s.data               = '0;
    return s;
  endfunction

  function automatic step_t fixed_step(input step_t s, input dipc_kind_e kind,
                                       input logic [7:0] b1, input logic [7:0] b2);
    step_t f;
    f                 = s;
    f.fixed           = 1'b1;
    f.res.kind        = kind;
    f.res.first_byte  = b1;
    f.res.second_byte = b2;
    return f;
  endfunction

  function automatic step_t reg_step(input logic [2:0] idx, input logic [7:0] data);
    step_t s;
    s      = item_step(CMD_POLL, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, PORT_NONE);
    s.kind = STEP_REG;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic phase_t mk_phase(input logic [7:0] deb, input logic en,
                                      input logic [7:0] mask_a, input logic [7:0] mask_b,
                                      input logic [7:0] out_mask, input int unsigned tx_idle,
                                      input int unsigned rx_stall, input int unsigned n,
                                      input bit hold, input bit heavy);
    phase_t ph;
    ph.cfg.debounce_polls = deb;
    ph.cfg.cos_enable     = en;
    ph.cfg.cos_mask_a     = mask_a;
    ph.cfg.cos_mask_b     = mask_b;
    ph.cfg.out_mask       = out_mask;
    ph.tx_idle            = tx_idle;
    ph.rx_stall           = rx_stall;
    ph.n_items            = n;
    ph.hold               = hold;
    ph.poll_heavy         = heavy;
    return ph;
  endfunction

  // random item: mostly polls on pins that change now and then, with glitches
  function automatic dipc_item_t gen_item(input bit heavy);
    dipc_item_t  it;
    int unsigned r;
    r = $urandom_range(99);
    if (heavy) it.cmd = (r < 92) ? CMD_POLL : dipc_cmd_e'($urandom_range(3));
    else if (r < 55) it.cmd = CMD_POLL;
    else if (r < 70) it.cmd = CMD_WRITE;
    else if (r < 85) it.cmd = CMD_RD_IN;
    else it.cmd = CMD_RD_OUT;
    if ($urandom_range(99) < (heavy ? 1 : 10)) env_a = env_a ^ 8'($urandom);
    if ($urandom_range(99) < (heavy ? 1 : 10)) env_b = env_b ^ 8'($urandom);
    it.pins_a  = env_a;
    it.pins_b  = env_b;
    if (!heavy && $urandom_range(99) < 5) it.pins_a = 8'($urandom);
    if (!heavy && $urandom_range(99) < 5) it.pins_b = 8'($urandom);
    it.tx_busy = ($urandom_range(99) < 20);
    r = $urandom_range(99);
    if (r < 10) it.data_length = 4'd0;
    else if (r < 40) it.data_length = 4'd1;
    else if (r < 80) it.data_length = 4'd2;
    else it.data_length = 4'($urandom_range(15, 3));
    it.out_byte_a  = 8'($urandom);
    it.out_byte_b  = 8'($urandom);
    it.port_select = 2'($urandom_range(3));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one item, with random sender gaps first, and wait for its transfer
  task automatic send_item(input dipc_item_t it, input bit fixed, input dipc_res_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= it.cmd;
    cmd_if.pins_a      <= it.pins_a;
    cmd_if.pins_b      <= it.pins_b;
    cmd_if.tx_busy     <= it.tx_busy;
    cmd_if.data_length <= it.data_length;
    cmd_if.out_byte_a  <= it.out_byte_a;
    cmd_if.out_byte_b  <= it.out_byte_b;
    cmd_if.port_select <= it.port_select;
    fixed_on           <= fixed;
    fixed_res          <= res;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
  endtask

  // register write at the next edge; the caller lowers the enable after a group
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    set_port_reg(idx, data);
    @(posedge clk_i);
  endtask

  // stop offering, wait for every owed result, then let items with no result drain
  task automatic drain_ports();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // clock, receiver, hold-off, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls per phase, forced low during the hold-off
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // one long stretch with no result transfers while items keep coming, so the
  // block fills up and has to push back on its input
  initial begin
    hold_off <= 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // monitor and checker: predict on each item transfer, compare each result transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      seen_item.cmd         = cmd_if.cmd;
      seen_item.pins_a      = cmd_if.pins_a;
      seen_item.pins_b      = cmd_if.pins_b;
      seen_item.tx_busy     = cmd_if.tx_busy;
      seen_item.data_length = cmd_if.data_length;
      seen_item.out_byte_a  = cmd_if.out_byte_a;
      seen_item.out_byte_b  = cmd_if.out_byte_b;
      seen_item.port_select = cmd_if.port_select;
      // the predictor runs on every item so its state stays in step
      seen_hit = predict_ports(seen_item, seen_res);
      if (fixed_on) expected_q.push_back(fixed_res);
      else if (seen_hit) expected_q.push_back(seen_res);
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("unexpected result: kind %0d first %02h second %02h",
                   res_if.kind, res_if.first_byte, res_if.second_byte);
      end else begin
        want_res = expected_q.pop_front();
        if (res_if.kind !== want_res.kind || res_if.first_byte !== want_res.first_byte ||
            res_if.second_byte !== want_res.second_byte) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("mismatch: expected kind %0d first %02h second %02h, got %0d %02h %02h",
                     want_res.kind, want_res.first_byte, want_res.second_byte,
                     res_if.kind, res_if.first_byte, res_if.second_byte);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    dipc_res_t no_res;
    bit        in_reg;

    no_res             = '0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= '0;
    cfg_data_i         <= '0;
    cmd_if.valid       <= 1'b0;
    cmd_if.cmd         <= CMD_POLL;
    cmd_if.pins_a      <= '0;
    cmd_if.pins_b      <= '0;
    cmd_if.tx_busy     <= 1'b0;
    cmd_if.data_length <= '0;
    cmd_if.out_byte_a  <= '0;
    cmd_if.out_byte_b  <= '0;
    cmd_if.port_select <= '0;
    fixed_on           <= 1'b0;
    fixed_res          <= '0;
    reset_ports();

    // reset values, odd port numbers and the length error are typed in
    directed_steps.push_back(fixed_step(item_step(CMD_RD_OUT, 8'h00, 8'h00, 1'b0, 4'd0,
      8'h00, 8'h00, PORT_A), KIND_OUT_RD, LevelRst, 8'h00));
    directed_steps.push_back(fixed_step(item_step(CMD_RD_OUT, 8'h00, 8'h00, 1'b0, 4'd0,
      8'h00, 8'h00, PORT_B), KIND_OUT_RD, LevelRst, 8'h00));
    directed_steps.push_back(fixed_step(item_step(CMD_RD_OUT, 8'hFF, 8'hFF, 1'b0, 4'd0,
      8'h00, 8'h00, PORT_NONE), KIND_OUT_RD, 8'h00, 8'h00));
    directed_steps.push_back(fixed_step(item_step(CMD_RD_IN, 8'hFF, 8'hFF, 1'b0, 4'd0,
      8'h00, 8'h00, PORT_RSVD), KIND_IN_READ, 8'h00, 8'h00));
    directed_steps.push_back(fixed_step(item_step(CMD_RD_IN, 8'hFF, 8'hFF, 1'b0, 4'd0,
      8'h00, 8'h00, PORT_A), KIND_IN_READ, 8'hFF, 8'h00));
    // all of port b is output after reset, so its input read is zero
    directed_steps.push_back(fixed_step(item_step(CMD_RD_IN, 8'h00, 8'hFF, 1'b0, 4'd0,
      8'h00, 8'h00, PORT_B), KIND_IN_READ, 8'h00, 8'h00));
    directed_steps.push_back(fixed_step(item_step(CMD_WRITE, 8'h00, 8'h00, 1'b0, 4'd0,
      8'hFF, 8'hFF, PORT_A), KIND_LEN_ERR, LenErrByte1, LenErrByte2));
    // poll with reporting off does nothing
    directed_steps.push_back(item_step(CMD_POLL, 8'hFF, 8'hFF, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_NONE));
    // one-byte write hits port a only, then the longest length
    directed_steps.push_back(item_step(CMD_WRITE, 8'h00, 8'h00, 1'b0, 4'd1, 8'h00, 8'h00,
      PORT_A));
    directed_steps.push_back(item_step(CMD_RD_OUT, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_A));
    directed_steps.push_back(item_step(CMD_RD_OUT, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_B));
    directed_steps.push_back(item_step(CMD_WRITE, 8'h00, 8'h00, 1'b0, 4'd15, 8'hFF, 8'h00,
      PORT_B));
    directed_steps.push_back(item_step(CMD_RD_OUT, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_B));
    // split port b, report on the first differing poll, and poke an unused index
    directed_steps.push_back(reg_step(REG_OUT_MASK, 8'h0F));
    directed_steps.push_back(reg_step(REG_DEBOUNCE, 8'h00));
    directed_steps.push_back(reg_step(REG_COS_EN, 8'h01));
    directed_steps.push_back(reg_step(REG_MASK_A, 8'hFF));
    directed_steps.push_back(reg_step(REG_MASK_B, 8'hFF));
    directed_steps.push_back(reg_step(RegNone, 8'hAA));
    directed_steps.push_back(item_step(CMD_RD_IN, 8'h00, 8'hFF, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_B));
    // pull-up bits of port b must survive a two-byte write
    directed_steps.push_back(item_step(CMD_WRITE, 8'h00, 8'h00, 1'b0, 4'd2, 8'h5A, 8'hFF,
      PORT_B));
    directed_steps.push_back(item_step(CMD_RD_OUT, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_B));
    directed_steps.push_back(item_step(CMD_POLL, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_NONE));
    // busy transmitter keeps the change pending, next free poll reports it
    directed_steps.push_back(item_step(CMD_POLL, 8'h80, 8'h00, 1'b1, 4'd0, 8'h00, 8'h00,
      PORT_NONE));
    directed_steps.push_back(item_step(CMD_POLL, 8'h80, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_NONE));
    directed_steps.push_back(item_step(CMD_POLL, 8'h80, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_NONE));
    // debounce of two: report on the third differing poll in a row
    directed_steps.push_back(reg_step(REG_DEBOUNCE, 8'h02));
    repeat (3)
      directed_steps.push_back(item_step(CMD_POLL, 8'h80, 8'hF0, 1'b0, 4'd0, 8'h00, 8'h00,
        PORT_NONE));
    // change on output-only bits is masked off the input side
    directed_steps.push_back(item_step(CMD_POLL, 8'h80, 8'h0F, 1'b0, 4'd0, 8'h00, 8'h00,
      PORT_NONE));

    // random phases: every idling mode, extremes of the registers, one long hold-off
    phases.push_back(mk_phase(8'd0, 1'b1, 8'hFF, 8'hFF, 8'h00, 0, 0, 180, 1'b0, 1'b0));
    phases.push_back(mk_phase(8'd3, 1'b1, 8'h0F, 8'hFF, 8'hF0, 50, 0, 180, 1'b0, 1'b0));
    phases.push_back(mk_phase(8'd1, 1'b1, 8'hFF, 8'h3C, 8'hFF, 0, 50, 180, 1'b0, 1'b0));
    // largest debounce, stored as 254: long runs of polls on held pins
    phases.push_back(mk_phase(DebounceTop, 1'b1, 8'hFF, 8'hFF, 8'h00, 20, 20, 320, 1'b0,
                              1'b1));
    phases.push_back(mk_phase(8'd2, 1'b0, 8'hFF, 8'hFF, 8'h55, 0, 0, 150, 1'b1, 1'b0));
    phases.push_back(mk_phase(8'($urandom_range(8)), 1'b1, 8'($urandom), 8'($urandom),
                              8'($urandom), 20, 20, 150, 1'b0, 1'b0));
    phases.push_back(mk_phase(8'($urandom_range(6)), 1'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 50, 0, 150, 1'b0, 1'b0));
    phases.push_back(mk_phase(8'd0, 1'b1, 8'h00, 8'h00, 8'hFF, 0, 50, 140, 1'b0, 1'b0));

    // reset held low at the start and released here; it is not asserted again
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; register rows are written only once the block has gone idle
    in_reg = 1'b0;
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_REG) begin
        if (!in_reg) drain_ports();
        write_reg(directed_steps[i].idx, directed_steps[i].data);
        in_reg = 1'b1;
      end else begin
        if (in_reg) cfg_we_i <= 1'b0;
        in_reg = 1'b0;
        send_item(directed_steps[i].item, directed_steps[i].fixed, directed_steps[i].res);
      end
    end

    foreach (phases[p]) begin
      drain_ports();
      write_reg(REG_DEBOUNCE, phases[p].cfg.debounce_polls);
      write_reg(REG_COS_EN, {7'd0, phases[p].cfg.cos_enable});
      write_reg(REG_MASK_A, phases[p].cfg.cos_mask_a);
      write_reg(REG_MASK_B, phases[p].cfg.cos_mask_b);
      write_reg(REG_OUT_MASK, phases[p].cfg.out_mask);
      cfg_we_i     <= 1'b0;
      tx_idle_pct  = phases[p].tx_idle;
      rx_stall_pct = phases[p].rx_stall;
      if (phases[p].hold) hold_go = 1'b1;
      repeat (phases[p].n_items) send_item(gen_item(phases[p].poll_heavy), 1'b0, no_res);
    end

    // all items sent: wait out the owed results and the pipeline
    drain_ports();
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
